// ===== rtl/hcpu_pkg.sv =====
// Package: payload types, opcode constants and sequencer states of the Hack CPU core.
package hcpu_pkg;

  typedef struct packed {
    logic        [15:0] instruction;
    logic signed [15:0] mem_read_data;
  } in_beat_t;

  typedef struct packed {
    logic        [15:0] next_pc;
    logic               mem_write;
    logic        [14:0] mem_addr;
    logic signed [15:0] mem_wdata;
    logic signed [15:0] a_value;
    logic               swi_valid;
    logic signed [15:0] swi_code;
    logic signed [15:0] swi_arg;
    logic               halted;
    logic        [2:0]  status;
  } out_beat_t;

  localparam logic [5:0] OP_AND  = 6'h00;
  localparam logic [5:0] OP_ADD  = 6'h02;
  localparam logic [5:0] OP_YMD  = 6'h07;
  localparam logic [5:0] OP_D    = 6'h0C;
  localparam logic [5:0] OP_ND   = 6'h0D;
  localparam logic [5:0] OP_DM1  = 6'h0E;
  localparam logic [5:0] OP_NEGD = 6'h0F;
  localparam logic [5:0] OP_DMY  = 6'h13;
  localparam logic [5:0] OP_OR   = 6'h15;
  localparam logic [5:0] OP_DP1  = 6'h1F;
  localparam logic [5:0] OP_SHL  = 6'h20;
  localparam logic [5:0] OP_SAR  = 6'h21;
  localparam logic [5:0] OP_MUL  = 6'h22;
  localparam logic [5:0] OP_DIV  = 6'h23;
  localparam logic [5:0] OP_MOD  = 6'h24;
  localparam logic [5:0] OP_LT   = 6'h25;
  localparam logic [5:0] OP_LE   = 6'h26;
  localparam logic [5:0] OP_GT   = 6'h27;
  localparam logic [5:0] OP_GE   = 6'h28;
  localparam logic [5:0] OP_EQ   = 6'h29;
  localparam logic [5:0] OP_ZERO = 6'h2A;
  localparam logic [5:0] OP_NE   = 6'h2B;
  localparam logic [5:0] OP_XOR  = 6'h2C;
  localparam logic [5:0] OP_CALL = 6'h2D;
  localparam logic [5:0] OP_RET  = 6'h2E;
  localparam logic [5:0] OP_SWI  = 6'h2F;
  localparam logic [5:0] OP_Y    = 6'h30;
  localparam logic [5:0] OP_NY   = 6'h31;
  localparam logic [5:0] OP_YM1  = 6'h32;
  localparam logic [5:0] OP_NEGY = 6'h33;
  localparam logic [5:0] OP_IRET = 6'h34;
  localparam logic [5:0] OP_YP1  = 6'h37;
  localparam logic [5:0] OP_M1   = 6'h3A;
  localparam logic [5:0] OP_ONE  = 6'h3F;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_IRQ     = 3'd1;
  localparam logic [2:0] ST_ILLEGAL = 3'd2;
  localparam logic [2:0] ST_BADOP   = 3'd3;
  localparam logic [2:0] ST_DIVZERO = 3'd4;

  localparam logic [15:0] IRQ_VECTOR = 16'd2;

  localparam logic [0:0] REG_PERIOD = 1'b0;
  localparam logic [0:0] REG_PLEN   = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MUL,
    S_DIV,
    S_FIN,
    S_OUT
  } seq_state_e;

  typedef enum logic [1:0] {
    MD_MUL,
    MD_DIV,
    MD_MOD
  } md_op_e;

  typedef struct packed {
    logic   start;
    md_op_e op;
  } md_ctrl_t;

endpackage

// ===== rtl/hcpu_muldiv.sv =====
// Shared iterative unit: shift-add multiply and restoring signed divide, one bit a cycle.
module hcpu_muldiv (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hcpu_pkg::md_ctrl_t  ctrl_i,
  input  logic [15:0]         d_i,
  input  logic [15:0]         y_i,
  output logic                done_o,
  output logic [15:0]         res_o
);
  import hcpu_pkg::*;

  logic        busy_q, busy_d;
  logic [3:0]  cnt_q, cnt_d;
  md_op_e      op_q, op_d;
  logic [15:0] acc_q, acc_d;     // product or partial remainder
  logic [15:0] sh_q, sh_d;       // multiplier bits or dividend/quotient bits
  logic [15:0] div_q, div_d;     // multiplicand or divisor magnitude
  logic        qneg_q, qneg_d, rneg_q, rneg_d;

  logic [15:0] d_mag, y_mag;
  logic [16:0] trial;
  logic [15:0] r_next, q_res, r_res;

  assign d_mag = d_i[15] ? 16'(-d_i) : d_i;
  assign y_mag = y_i[15] ? 16'(-y_i) : y_i;
  assign trial = {acc_q, sh_q[15]} - {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    op_d   = op_q;
    acc_d  = acc_q;
    sh_d   = sh_q;
    div_d  = div_q;
    qneg_d = qneg_q;
    rneg_d = rneg_q;
    r_next = '0;
    if (ctrl_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      op_d   = ctrl_i.op;
      acc_d  = '0;
      qneg_d = d_i[15] ^ y_i[15];
      rneg_d = d_i[15];
      if (ctrl_i.op == MD_MUL) begin
        sh_d  = y_i;
        div_d = d_i;
      end else begin
        sh_d  = d_mag;
        div_d = y_mag;
      end
    end else if (busy_q) begin
      cnt_d = cnt_q + 4'd1;
      if (cnt_q == 4'd15) busy_d = 1'b0;
      if (op_q == MD_MUL) begin
        acc_d = (acc_q << 1) + (sh_q[15] ? div_q : 16'd0);
        sh_d  = sh_q << 1;
      end else begin
        if (!trial[16]) begin
          r_next = trial[15:0];
          sh_d   = {sh_q[14:0], 1'b1};
        end else begin
          r_next = {acc_q[14:0], sh_q[15]};
          sh_d   = {sh_q[14:0], 1'b0};
        end
        acc_d = r_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= MD_MUL;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    sh_q   <= sh_d;
    div_q  <= div_d;
    qneg_q <= qneg_d;
    rneg_q <= rneg_d;
  end

  assign q_res  = qneg_q ? 16'(-sh_q) : sh_q;
  assign r_res  = rneg_q ? 16'(-acc_q) : acc_q;
  assign done_o = !busy_q;
  always_comb begin
    case (op_q)
      MD_MUL:  res_o = acc_q;
      MD_DIV:  res_o = q_res;
      default: res_o = r_res;
    endcase
  end
endmodule

// ===== rtl/hack_cpu_extended_core_unit.sv =====
// Top level of the Hack CPU core: architectural state, sequencer, ALU and config port.
// One instruction is taken per input beat and gives one result beat. A instructions, call,
// ret, swi, iret, illegal words and timer entries pass through accept, execute and output;
// other C instructions add a write-back state, a divide by zero included; multiply, divide
// and modulo also wait on the 16-step shared multiply/divide unit before write-back.
// Result stalls hold the output beat. The input is not ready (in_stall_o high) from accept
// until the result beat is taken.
module hack_cpu_extended_core_unit #(
  parameter int MEM_WORDS    = 32768,
  parameter int PERIOD_SHIFT = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  hcpu_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output hcpu_pkg::out_beat_t out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import hcpu_pkg::*;

  localparam int AW = $clog2(MEM_WORDS);

  seq_state_e  state_q, state_d;
  logic [15:0] a_q, a_d, d_q, d_d, pc_q, pc_d, lr_q, lr_d, ilr_q, ilr_d;
  logic [15:0] sa_q, sa_d, sd_q, sd_d;
  logic        inint_q, inint_d;
  logic [31:0] tick_q, tick_d;
  logic [15:0] period_q, plen_q;
  in_beat_t    ib_q;
  out_beat_t   ob_q, ob_d;
  logic [15:0] res_q, res_d;
  logic [2:0]  code_q, code_d;

  md_ctrl_t    md_ctrl;
  logic        md_done;
  logic [15:0] md_res;

  logic [47:0] period_full;
  logic [31:0] tick_inc;
  logic        tick;
  logic [5:0]  op;
  logic [15:0] y, alu_r;
  logic [2:0]  alu_code;
  logic        take;
  logic        sy_zero;
  logic [15:0] a_new, pc_inc;
  logic signed [15:0] sd, sy, sr;

  assign pready = 1'b1;
  always_comb begin
    unique case (paddr[2])
      REG_PERIOD: prdata = {16'd0, period_q};
      default:    prdata = {16'd0, plen_q};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= '0;
      plen_q   <= 16'h8000;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      if (paddr[2] == REG_PERIOD) period_q <= pwdata[15:0];
      else                        plen_q   <= pwdata[15:0];
    end
  end

  assign op      = ib_q.instruction[11:6];
  assign y       = ib_q.instruction[12] ? ib_q.mem_read_data : a_q;
  assign sd      = d_q;
  assign sy      = y;
  assign sy_zero = (y == 16'd0);

  always_comb begin
    alu_r    = '0;
    alu_code = ST_OK;
    case (op)
      OP_AND:  alu_r = d_q & y;
      OP_ADD:  alu_r = d_q + y;
      OP_YMD:  alu_r = y - d_q;
      OP_D:    alu_r = d_q;
      OP_ND:   alu_r = ~d_q;
      OP_DM1:  alu_r = d_q - 16'd1;
      OP_NEGD: alu_r = 16'(-d_q);
      OP_DMY:  alu_r = d_q - y;
      OP_OR:   alu_r = d_q | y;
      OP_DP1:  alu_r = d_q + 16'd1;
      OP_ZERO: alu_r = '0;
      OP_Y:    alu_r = y;
      OP_NY:   alu_r = ~y;
      OP_YM1:  alu_r = y - 16'd1;
      OP_NEGY: alu_r = 16'(-y);
      OP_YP1:  alu_r = y + 16'd1;
      OP_M1:   alu_r = 16'hFFFF;
      OP_ONE:  alu_r = 16'd1;
      OP_SHL:  alu_r = (y[15:4] != 12'd0) ? 16'd0 : (d_q << y[3:0]);
      OP_SAR:  alu_r = (y[15:4] != 12'd0) ? {16{d_q[15]}} : 16'(sd >>> y[3:0]);
      OP_LT:   alu_r = {15'd0, sd < sy};
      OP_LE:   alu_r = {15'd0, sd <= sy};
      OP_GT:   alu_r = {15'd0, sd > sy};
      OP_GE:   alu_r = {15'd0, sd >= sy};
      OP_EQ:   alu_r = {15'd0, sd == sy};
      OP_NE:   alu_r = {15'd0, sd != sy};
      OP_XOR:  alu_r = d_q ^ y;
      OP_MUL, OP_DIV, OP_MOD: alu_r = '0;
      default: alu_code = ST_BADOP;
    endcase
  end

  assign period_full = {32'd0, period_q} << PERIOD_SHIFT;
  assign tick_inc    = tick_q + 32'd1;
  assign tick = (period_full != 48'd0) && ({16'd0, tick_inc} >= period_full);
  assign pc_inc = pc_q + 16'd1;
  assign sr = res_q;
  assign a_new = ib_q.instruction[5] ? res_q : a_q;

  always_comb begin
    unique case (ib_q.instruction[2:0])
      3'd1:    take = sr > 0;
      3'd2:    take = sr == 0;
      3'd3:    take = sr >= 0;
      3'd4:    take = sr < 0;
      3'd5:    take = sr != 0;
      3'd6:    take = sr <= 0;
      3'd7:    take = 1'b1;
      default: take = 1'b0;
    endcase
  end

  hcpu_muldiv u_md (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (md_ctrl),
    .d_i    (d_q),
    .y_i    (y),
    .done_o (md_done),
    .res_o  (md_res)
  );

  always_comb begin
    state_d = state_q;
    a_d = a_q; d_d = d_q; pc_d = pc_q; lr_d = lr_q; ilr_d = ilr_q;
    sa_d = sa_q; sd_d = sd_q; inint_d = inint_q; tick_d = tick_q;
    ob_d = ob_q; res_d = res_q; code_d = code_q;
    md_ctrl.start = 1'b0;
    md_ctrl.op    = MD_MUL;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_EXEC;
      S_EXEC: begin
        ob_d = '0;
        tick_d = tick ? 32'd0 : tick_inc;
        if (tick && !inint_q) begin
          sa_d = a_q; sd_d = d_q; ilr_d = pc_q; pc_d = IRQ_VECTOR; inint_d = 1'b1;
          ob_d.status = ST_IRQ;
          state_d = S_OUT;
        end else begin
          pc_d = pc_inc;
          state_d = S_OUT;
          if (ib_q.instruction[15:13] == 3'b111) begin
            unique case (op)
              OP_CALL: begin lr_d = pc_inc; pc_d = a_q; end
              OP_RET:  pc_d = lr_q;
              OP_SWI: begin
                ob_d.swi_valid = 1'b1; ob_d.swi_code = a_q; ob_d.swi_arg = d_q;
              end
              OP_IRET: begin
                a_d = sa_q; d_d = sd_q; pc_d = ilr_q; inint_d = 1'b0;
              end
              default: begin
                res_d  = alu_r;
                code_d = alu_code;
                state_d = S_FIN;
                if (op == OP_MUL) begin
                  md_ctrl.start = 1'b1; state_d = S_MUL;
                end else if (op == OP_DIV || op == OP_MOD) begin
                  if (sy_zero) begin
                    res_d  = (op == OP_DIV) ? 16'hFFFF : d_q;
                    code_d = ST_DIVZERO;
                  end else begin
                    md_ctrl.start = 1'b1;
                    md_ctrl.op = (op == OP_DIV) ? MD_DIV : MD_MOD;
                    state_d = S_DIV;
                  end
                end
              end
            endcase
          end else if (!ib_q.instruction[15]) begin
            a_d = ib_q.instruction;
          end else begin
            ob_d.status = ST_ILLEGAL;
          end
        end
      end
      S_MUL, S_DIV: begin
        if (md_done) begin
          res_d = md_res;
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (ib_q.instruction[5]) a_d = res_q;
        if (ib_q.instruction[4]) d_d = res_q;
        if (ib_q.instruction[3]) begin
          ob_d.mem_write = 1'b1;
          ob_d.mem_addr  = 15'(a_new[AW-1:0]);
          ob_d.mem_wdata = res_q;
        end
        if (take) pc_d = a_new;
        ob_d.status = code_q;
        state_d = S_OUT;
      end
      S_OUT: if (!out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
    ob_d.next_pc = pc_d;
    ob_d.a_value = a_d;
    ob_d.halted  = (pc_d >= plen_q);
    if (state_q == S_OUT || state_q == S_IDLE || state_q == S_MUL || state_q == S_DIV) begin
      ob_d.next_pc = ob_q.next_pc;
      ob_d.a_value = ob_q.a_value;
      ob_d.halted  = ob_q.halted;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      a_q <= '0; d_q <= '0; pc_q <= '0; lr_q <= '0; ilr_q <= '0;
      sa_q <= '0; sd_q <= '0; inint_q <= 1'b0; tick_q <= '0;
    end else begin
      state_q <= state_d;
      a_q <= a_d; d_q <= d_d; pc_q <= pc_d; lr_q <= lr_d; ilr_q <= ilr_d;
      sa_q <= sa_d; sd_q <= sd_d; inint_q <= inint_d; tick_q <= tick_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) ib_q <= in_data_i;
    ob_q   <= ob_d;
    res_q  <= res_d;
    code_q <= code_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign out_data_o  = ob_q;
endmodule

// ===== rtl/hcpu_checker.sv =====
// Port-level checker for the Hack CPU core, bound to the top level.
module hcpu_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input hcpu_pkg::out_beat_t out_data_o
);
  import hcpu_pkg::*;

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input accepted while result pending");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o) else $error("input ready after accept");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_wr_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.mem_write |-> out_data_o.mem_addr == '0
      && out_data_o.mem_wdata == '0) else $error("write fields set without write");

  a_swi_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.swi_valid |-> out_data_o.status == ST_OK)
    else $error("swi with nonzero status");
endmodule

bind hack_cpu_extended_core_unit hcpu_checker u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ===== tb/sv/testbench.sv =====
// Testbench for the Hack CPU core: random and directed instruction stream, checked against a predictor.
`timescale 1ns / 100ps

module testbench;
  import hcpu_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_beat_t    in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_beat_t   out_data_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  hack_cpu_extended_core_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  localparam logic [5:0] KNOWN_OPS [34] = '{
    OP_AND, OP_ADD, OP_YMD, OP_D, OP_ND, OP_DM1, OP_NEGD, OP_DMY, OP_OR, OP_DP1,
    OP_SHL, OP_SAR, OP_MUL, OP_DIV, OP_MOD, OP_LT, OP_LE, OP_GT, OP_GE, OP_EQ,
    OP_ZERO, OP_NE, OP_XOR, OP_CALL, OP_RET, OP_SWI, OP_Y, OP_NY, OP_YM1, OP_NEGY,
    OP_IRET, OP_YP1, OP_M1, OP_ONE
  };
  localparam logic [2:0] DST_A = 3'b100;
  localparam logic [2:0] DST_D = 3'b010;
  localparam logic [2:0] DST_M = 3'b001;
  localparam int WATCHDOG_LIMIT = 4000;

  // predictor state
  logic [15:0] cfg_period, cfg_plen;
  logic [15:0] core_a, core_d, core_pc, core_link, core_ilink, core_sa, core_sd;
  logic        core_inirq;
  logic [31:0] core_ticks;

  in_beat_t  instr_q [$];
  out_beat_t result_q [$];
  int        errors, beats_in, beats_out, irq_seen, divz_seen, swi_seen;
  logic      calm, hold_arm, hold_used;
  int        in_gap, out_gap, hold_left, idle_cycles;

  function automatic logic [15:0] alu_eval(logic [5:0] op, logic [15:0] d, logic [15:0] y,
                                           output logic [2:0] code);
    int          sd, sy, q;
    logic [31:0] p;
    logic [15:0] r;
    sd = $signed(d);
    sy = $signed(y);
    code = ST_OK;
    r = '0;
    case (op)
      OP_AND:  r = d & y;
      OP_ADD:  r = d + y;
      OP_YMD:  r = y - d;
      OP_D:    r = d;
      OP_ND:   r = ~d;
      OP_DM1:  r = d - 16'd1;
      OP_NEGD: r = -d;
      OP_DMY:  r = d - y;
      OP_OR:   r = d | y;
      OP_DP1:  r = d + 16'd1;
      OP_ZERO: r = '0;
      OP_Y:    r = y;
      OP_NY:   r = ~y;
      OP_YM1:  r = y - 16'd1;
      OP_NEGY: r = -y;
      OP_YP1:  r = y + 16'd1;
      OP_M1:   r = 16'hFFFF;
      OP_ONE:  r = 16'd1;
      OP_SHL:  r = (y >= 16) ? 16'd0 : d << y;
      OP_SAR:  r = (y >= 16) ? {16{d[15]}} : 16'($signed(d) >>> y);
      OP_MUL: begin
        p = d * y;
        r = p[15:0];
      end
      OP_DIV: begin
        if (sy == 0) begin
          r = 16'hFFFF;
          code = ST_DIVZERO;
        end else begin
          q = sd / sy;
          r = q[15:0];
        end
      end
      OP_MOD: begin
        if (sy == 0) begin
          r = d;
          code = ST_DIVZERO;
        end else begin
          q = sd % sy;
          r = q[15:0];
        end
      end
      OP_LT:   r = {15'd0, sd < sy};
      OP_LE:   r = {15'd0, sd <= sy};
      OP_GT:   r = {15'd0, sd > sy};
      OP_GE:   r = {15'd0, sd >= sy};
      OP_EQ:   r = {15'd0, sd == sy};
      OP_NE:   r = {15'd0, sd != sy};
      OP_XOR:  r = d ^ y;
      default: code = ST_BADOP;
    endcase
    return r;
  endfunction

  function automatic out_beat_t core_step(in_beat_t b);
    out_beat_t   o;
    logic [15:0] ins, y, r;
    logic [5:0]  op;
    logic [2:0]  dst, code;
    logic [31:0] period;
    logic        tick, take;
    o = '0;
    ins = b.instruction;
    tick = 1'b0;
    period = {16'd0, cfg_period} << 12;
    core_ticks = core_ticks + 1;
    if (period != 0 && core_ticks >= period) begin
      core_ticks = 0;
      tick = 1'b1;
    end
    if (tick && !core_inirq) begin
      core_sa = core_a;
      core_sd = core_d;
      core_ilink = core_pc;
      core_pc = IRQ_VECTOR;
      core_inirq = 1'b1;
      o.status = ST_IRQ;
    end else begin
      core_pc = core_pc + 16'd1;
      if (ins[15:13] == 3'b111) begin
        op = ins[11:6];
        dst = ins[5:3];
        if (op == OP_CALL) begin
          core_link = core_pc;
          core_pc = core_a;
        end else if (op == OP_RET) begin
          core_pc = core_link;
        end else if (op == OP_SWI) begin
          o.swi_valid = 1'b1;
          o.swi_code = core_a;
          o.swi_arg = core_d;
        end else if (op == OP_IRET) begin
          core_a = core_sa;
          core_d = core_sd;
          core_pc = core_ilink;
          core_inirq = 1'b0;
        end else begin
          y = ins[12] ? b.mem_read_data : core_a;
          r = alu_eval(op, core_d, y, code);
          o.status = code;
          if (dst[2]) core_a = r;
          if (dst[1]) core_d = r;
          if (dst[0]) begin
            o.mem_write = 1'b1;
            o.mem_addr = core_a[14:0];
            o.mem_wdata = r;
          end
          case (ins[2:0])
            3'd1: take = $signed(r) > 0;
            3'd2: take = r == 0;
            3'd3: take = $signed(r) >= 0;
            3'd4: take = $signed(r) < 0;
            3'd5: take = r != 0;
            3'd6: take = $signed(r) <= 0;
            3'd7: take = 1'b1;
            default: take = 1'b0;
          endcase
          if (take) core_pc = core_a;
        end
      end else if (!ins[15]) begin
        core_a = ins;
      end else begin
        o.status = ST_ILLEGAL;
      end
    end
    o.next_pc = core_pc;
    o.a_value = core_a;
    o.halted = core_pc >= cfg_plen;
    return o;
  endfunction

  function automatic in_beat_t c_instr(logic a, logic [5:0] op, logic [2:0] dst,
                                       logic [2:0] jmp, logic [15:0] mrd);
    in_beat_t b;
    b.instruction = {3'b111, a, op, dst, jmp};
    b.mem_read_data = mrd;
    return b;
  endfunction

  function automatic bit op_known(logic [5:0] op);
    foreach (KNOWN_OPS[i]) if (KNOWN_OPS[i] == op) return 1'b1;
    return 1'b0;
  endfunction

  function automatic in_beat_t rand_instr();
    in_beat_t    b;
    int          k;
    logic [5:0]  op;
    logic [15:0] mrd;
    logic [15:0] edges [9] = '{16'h0, 16'hFFFF, 16'h1, 16'h8000, 16'h7FFF,
                              16'd15, 16'd16, 16'd17, 16'd31};
    k = $urandom_range(0, 99);
    mrd = ($urandom_range(0, 3) == 0) ? edges[$urandom_range(0, 8)] : 16'($urandom);
    if (k < 25) begin
      b.instruction = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 20))
                                                  : {1'b0, 15'($urandom)};
      b.mem_read_data = mrd;
    end else if (k < 30) begin
      b.instruction = {3'($urandom_range(4, 6)), 13'($urandom)};
      b.mem_read_data = mrd;
    end else if (k < 33) begin
      do op = 6'($urandom); while (op_known(op));
      b = c_instr(1'($urandom), op, 3'($urandom), 3'($urandom), mrd);
    end else begin
      b = c_instr(1'($urandom), KNOWN_OPS[$urandom_range(0, 33)], 3'($urandom),
                  ($urandom_range(0, 9) < 7) ? 3'd0 : 3'($urandom), mrd);
    end
    return b;
  endfunction

  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (calm || k < 55) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // input driver
  always @(posedge clk_i or negedge rst_ni) begin
    logic     v;
    in_beat_t b;
    out_beat_t e;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
      in_gap = 0;
    end else begin
      v = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        e = core_step(in_data_i);
        if (e.status == ST_IRQ) irq_seen++;
        if (e.status == ST_DIVZERO) divz_seen++;
        if (e.swi_valid) swi_seen++;
        result_q.push_back(e);
        beats_in++;
        v = 1'b0;
      end
      if (!v) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (instr_q.size() > 0) begin
          b = instr_q.pop_front();
          in_data_i <= b;
          v = 1'b1;
          in_gap = pick_gap();
        end
      end
      in_valid_i <= v;
    end
  end

  task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // result monitor and receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t e;
    logic      s;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      out_gap = 0;
      hold_left = 0;
      hold_used = 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        beats_out++;
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result beat, next_pc %h", $time, out_data_o.next_pc);
          errors++;
        end else begin
          e = result_q.pop_front();
          check_field("next_pc", e.next_pc, out_data_o.next_pc);
          check_field("mem_write", 16'(e.mem_write), 16'(out_data_o.mem_write));
          check_field("mem_addr", 16'(e.mem_addr), 16'(out_data_o.mem_addr));
          check_field("mem_wdata", e.mem_wdata, out_data_o.mem_wdata);
          check_field("a_value", e.a_value, out_data_o.a_value);
          check_field("swi_valid", 16'(e.swi_valid), 16'(out_data_o.swi_valid));
          check_field("swi_code", e.swi_code, out_data_o.swi_code);
          check_field("swi_arg", e.swi_arg, out_data_o.swi_arg);
          check_field("halted", 16'(e.halted), 16'(out_data_o.halted));
          check_field("status", 16'(e.status), 16'(out_data_o.status));
        end
      end
      if (hold_arm && !hold_used) begin
        hold_used = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        s = 1'b1;
      end else if (out_gap > 0) begin
        out_gap--;
        s = 1'b1;
      end else begin
        out_gap = pick_gap();
        s = out_gap > 0;
        if (s) out_gap--;
      end
      out_stall_i <= s;
    end
  end

  // watchdog: cycles without any beat while work is outstanding
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else if (instr_q.size() > 0 || result_q.size() > 0 || in_valid_i) begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic reg_write(logic [2:0] addr, logic [15:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= {16'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == {REG_PERIOD, 2'b00}) cfg_period = value;
    else cfg_plen = value;
  endtask

  task automatic drain();
    while (instr_q.size() > 0 || in_valid_i || result_q.size() > 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic queue_random(int n);
    repeat (n) instr_q.push_back(rand_instr());
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errors = 0;
    beats_in = 0;
    beats_out = 0;
    irq_seen = 0;
    divz_seen = 0;
    swi_seen = 0;
    idle_cycles = 0;
    calm = 1'b0;
    hold_arm = 1'b0;
    cfg_period = 16'd0;
    cfg_plen = 16'd32768;
    {core_a, core_d, core_pc, core_link, core_ilink, core_sa, core_sd} = '0;
    core_inirq = 1'b0;
    core_ticks = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes and special cases
    instr_q.push_back('{16'h7FFF, 16'h0000});
    instr_q.push_back(c_instr(1'b0, OP_YP1, DST_D, 3'd0, 16'h7FFF));
    instr_q.push_back(c_instr(1'b1, OP_DIV, DST_M, 3'd0, 16'hFFFF));
    instr_q.push_back(c_instr(1'b1, OP_MOD, DST_M, 3'd0, 16'hFFFF));
    instr_q.push_back(c_instr(1'b1, OP_DIV, DST_M, 3'd0, 16'h0000));
    instr_q.push_back(c_instr(1'b1, OP_MOD, DST_M, 3'd0, 16'h0000));
    instr_q.push_back(c_instr(1'b1, OP_SHL, DST_M, 3'd0, 16'd15));
    instr_q.push_back(c_instr(1'b1, OP_SHL, DST_M, 3'd0, 16'd16));
    instr_q.push_back(c_instr(1'b1, OP_SAR, DST_M, 3'd0, 16'd16));
    instr_q.push_back(c_instr(1'b1, OP_SAR, DST_M, 3'd0, 16'hFFFF));
    instr_q.push_back(c_instr(1'b1, OP_MUL, DST_D | DST_M, 3'd0, 16'h8000));
    instr_q.push_back(c_instr(1'b1, 6'h01, DST_M, 3'd7, 16'h1234));
    instr_q.push_back('{16'h8000, 16'h0000});
    instr_q.push_back('{16'hA000, 16'h0000});
    instr_q.push_back('{16'hDFFF, 16'h0000});
    instr_q.push_back('{16'h0000, 16'h8000});
    instr_q.push_back(c_instr(1'b0, OP_CALL, 3'd0, 3'd0, 16'h0000));
    instr_q.push_back(c_instr(1'b0, OP_RET, 3'd0, 3'd0, 16'h0000));
    instr_q.push_back(c_instr(1'b0, OP_SWI, 3'd7, 3'd7, 16'h0000));
    instr_q.push_back(c_instr(1'b0, OP_IRET, 3'd0, 3'd0, 16'h0000));
    instr_q.push_back(c_instr(1'b1, OP_LT, DST_A | DST_D | DST_M, 3'd7, 16'h7FFF));
    instr_q.push_back(c_instr(1'b1, OP_M1, DST_D, 3'd4, 16'h0000));
    instr_q.push_back(c_instr(1'b1, OP_ONE, DST_A, 3'd1, 16'h0000));
    drain();

    // default setting, with one long receiver hold-off
    hold_arm <= 1'b1;
    queue_random(250);
    drain();

    // short timer period, halt on every PC
    reg_write({REG_PERIOD, 2'b00}, 16'd1);
    reg_write({REG_PLEN, 2'b00}, 16'd0);
    queue_random(200);
    drain();

    // longest period, full program, no idling
    calm = 1'b1;
    reg_write({REG_PERIOD, 2'b00}, 16'hFFFF);
    reg_write({REG_PLEN, 2'b00}, 16'd32768);
    queue_random(180);
    drain();

    calm = 1'b0;
    reg_write({REG_PERIOD, 2'b00}, 16'd0);
    reg_write({REG_PLEN, 2'b00}, 16'($urandom_range(1, 32767)));
    queue_random(200);
    drain();

    $display("Ran %0d instructions through %0d results: %0d timer entries, %0d divide by zero,",
             beats_in, beats_out, irq_seen, divz_seen);
    $display("%0d software interrupts, over four timer and program length settings.", swi_seen);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
